### design/pdvc_pkg.sv
// Shared types and constants of the preset dispense valve controller.
// Used by pdvc_tick and preset_dispense_valve_controller; no dependencies.
`default_nettype none

package pdvc_pkg;

    // Valve drive codes
    localparam logic [1:0] VALVE_STOP = 2'd0;
    localparam logic [1:0] VALVE_SLOW = 2'd1;
    localparam logic [1:0] VALVE_FAST = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_SLOW_START  = 2'd0;
    localparam logic [1:0] CFG_SLOW_END    = 2'd1;
    localparam logic [1:0] CFG_HOLD_TICKS  = 2'd2;

    localparam int unsigned CFG_IDX_BITS  = 2;
    localparam int unsigned CFG_DATA_BITS = 16;

    // Reset value of the totaliser hold time
    localparam logic [15:0] HOLD_TICKS_RESET = 16'd200;
    localparam logic [15:0] HOLD_TIMER_MAX   = 16'hFFFF;

    localparam int unsigned IN_TDATA_BITS  = 104;
    localparam int unsigned OUT_TDATA_BITS = 72;

    // One control tick as received
    typedef struct packed {
        logic [31:0] totaliser_value;
        logic [31:0] target_pulses;
        logic [31:0] pulse_count;
        logic        arm;
        logic        calibrating;
        logic        filling;
    } item_t;

    // One control tick result
    typedef struct packed {
        logic [31:0]        pulses_seen;
        logic signed [32:0] pulses_left;
        logic               dispense_done;
        logic               totaliser_drive;
        logic [1:0]         valve_cmd;
    } result_t;

endpackage

`default_nettype wire

### design/preset_dispense_valve_controller.sv
// Preset dispense valve controller, one channel, one control tick per transfer.
// Each tick passes the input register and then the result register. Throughput:
// one tick per cycle unless the result side stalls; the tick logic is one 33-bit subtract.
// Reset (aresetn low, synchronous) clears all channel state and both stages;
// configuration returns to slow start 0, slow end 0, hold 200 ticks.
// Uses pdvc_pkg and pdvc_tick.
`default_nettype none

module preset_dispense_valve_controller #(
    parameter int unsigned COUNT_BITS = 32
) (
    input  wire                                   aclk,
    input  wire                                   aresetn,
    // Configuration write port
    input  wire                                   cfg_wr_en,
    input  wire  [pdvc_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  wire  [pdvc_pkg::CFG_DATA_BITS-1:0]    cfg_wr_data,
    // Input stream
    input  wire                                   s_tvalid,
    output logic                                  s_tready,
    // filling, calibrating, arm, pulse_count[31:0], target_pulses[31:0],
    // totaliser_value[31:0], zero pad
    input  wire  [pdvc_pkg::IN_TDATA_BITS-1:0]    s_tdata,
    // Result stream
    output logic                                  m_tvalid,
    input  wire                                   m_tready,
    // valve_cmd[1:0], totaliser_drive, dispense_done, pulses_left[32:0],
    // pulses_seen[31:0], zero pad
    output logic [pdvc_pkg::OUT_TDATA_BITS-1:0]   m_tdata
);

    localparam int unsigned ITEM_BITS   = $bits(pdvc_pkg::item_t);
    localparam int unsigned RESULT_BITS = $bits(pdvc_pkg::result_t);

    pdvc_pkg::item_t   in_item_reg;
    logic              in_valid_reg;
    pdvc_pkg::result_t out_reg;
    logic              out_valid_reg;
    pdvc_pkg::result_t result;
    logic              advance;

    // Move the held tick forward when the result register frees up
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg <= pdvc_pkg::item_t'(s_tdata[ITEM_BITS-1:0]);
        end
    end

    pdvc_tick #(
        .COUNT_BITS (COUNT_BITS)
    ) u_tick (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .step        (advance),
        .item        (in_item_reg),
        .result      (result)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(pdvc_pkg::OUT_TDATA_BITS - RESULT_BITS){1'b0}}, out_reg};

`ifndef SYNTHESIS
    localparam logic [31:0] SEEN_MASK = 32'hFFFF_FFFF >> (32 - COUNT_BITS);

    // The valve code is never the unused fourth value
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[1:0] != 2'd3))
        else $error("valve code out of range");

    // Reported pulse count never carries bits above the counter width
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[68:37] & ~SEEN_MASK) == 32'd0))
        else $error("pulses_seen exceeds counter width");

    // A held tick that cannot advance stays held
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("input stage dropped a tick");

    // A stalled input stage keeps the upstream side stalled
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_valid_reg && !m_tready) |-> !s_tready)
        else $error("input accepted while stage full");
`endif

endmodule

`default_nettype wire

### design/pdvc_tick.sv
// Per-tick state update of the dispense channel: configuration registers,
// remaining count, completion flag, totaliser hold logic. Uses pdvc_pkg.
`default_nettype none

module pdvc_tick #(
    parameter int unsigned COUNT_BITS = 32
) (
    input  wire                                   aclk,
    input  wire                                   aresetn,
    input  wire                                   cfg_wr_en,
    input  wire  [pdvc_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  wire  [pdvc_pkg::CFG_DATA_BITS-1:0]    cfg_wr_data,
    input  wire                                   step,
    input  pdvc_pkg::item_t                       item,
    output pdvc_pkg::result_t                     result
);

    localparam logic [31:0] COUNT_MASK = 32'hFFFF_FFFF >> (32 - COUNT_BITS);

    logic [15:0]           slow_start_reg;
    logic [15:0]           slow_end_reg;
    logic [15:0]           hold_ticks_reg;

    logic [32:0]           remaining_reg, remaining_next;
    logic                  done_reg, done_next;
    logic [COUNT_BITS-1:0] latched_reg, latched_next;
    logic [31:0]           last_tot_reg, last_tot_next;
    logic [15:0]           timer_reg, timer_next;
    logic                  level_reg, level_next;

    logic [31:0]           count;
    logic [31:0]           target;
    logic [32:0]           rem_armed;
    logic                  armed_pos;
    logic [32:0]           rem_diff;
    logic                  diff_pos;
    logic                  cleared;
    logic                  hold_expired;
    logic [1:0]            valve;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slow_start_reg <= '0;
            slow_end_reg   <= '0;
            hold_ticks_reg <= pdvc_pkg::HOLD_TICKS_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                pdvc_pkg::CFG_SLOW_START: slow_start_reg <= cfg_wr_data;
                pdvc_pkg::CFG_SLOW_END:   slow_end_reg   <= cfg_wr_data;
                pdvc_pkg::CFG_HOLD_TICKS: hold_ticks_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Mask inputs to the counter width and apply the arm reload
    assign count     = item.pulse_count & COUNT_MASK;
    assign target    = item.target_pulses & COUNT_MASK;
    assign rem_armed = item.arm ? {1'b0, target} : remaining_reg;
    assign armed_pos = (rem_armed != '0) && !rem_armed[32];
    assign latched_next = armed_pos ? count[COUNT_BITS-1:0] : latched_reg;
    assign rem_diff  = {1'b0, target} - {{(33 - COUNT_BITS){1'b0}}, latched_next};
    assign diff_pos  = (rem_diff != '0) && !rem_diff[32];
    assign hold_expired = timer_reg > hold_ticks_reg;

    // Valve decision and remaining / done update
    always_comb begin
        remaining_next = rem_armed;
        done_next      = done_reg;
        valve          = pdvc_pkg::VALVE_STOP;
        if (item.filling) begin
            if (target != '0) begin
                if (armed_pos) begin
                    done_next      = 1'b0;
                    remaining_next = rem_diff;
                    if (!diff_pos) begin
                        valve = pdvc_pkg::VALVE_STOP;
                    end else if (rem_diff >= {17'd0, slow_end_reg}) begin
                        valve = ({{(32 - COUNT_BITS){1'b0}}, latched_next}
                                 >= {16'd0, slow_start_reg}) ?
                                pdvc_pkg::VALVE_FAST : pdvc_pkg::VALVE_SLOW;
                    end else begin
                        valve = pdvc_pkg::VALVE_SLOW;
                    end
                end else begin
                    done_next = 1'b1;
                    valve     = pdvc_pkg::VALVE_STOP;
                end
            end else begin
                valve = pdvc_pkg::VALVE_FAST;
            end
        end else begin
            done_next = 1'b0;
            valve     = item.calibrating ? pdvc_pkg::VALVE_FAST : pdvc_pkg::VALVE_STOP;
        end
    end

    // Totaliser output: set on change, release after the hold time
    always_comb begin
        cleared       = 1'b0;
        level_next    = level_reg;
        last_tot_next = last_tot_reg;
        if (item.filling) begin
            last_tot_next = item.totaliser_value;
            if (item.totaliser_value != last_tot_reg) begin
                cleared    = 1'b1;
                level_next = 1'b1;
            end else if (hold_expired) begin
                level_next = 1'b0;
            end
        end else if (hold_expired) begin
            level_next = 1'b0;
        end
        if (cleared) begin
            timer_next = '0;
        end else if (timer_reg != pdvc_pkg::HOLD_TIMER_MAX) begin
            timer_next = timer_reg + 16'd1;
        end else begin
            timer_next = timer_reg;
        end
    end

    // Commit state on each accepted tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            remaining_reg <= '0;
            done_reg      <= 1'b0;
            latched_reg   <= '0;
            last_tot_reg  <= '0;
            timer_reg     <= '0;
            level_reg     <= 1'b0;
        end else if (step) begin
            remaining_reg <= remaining_next;
            done_reg      <= done_next;
            latched_reg   <= latched_next;
            last_tot_reg  <= last_tot_next;
            timer_reg     <= timer_next;
            level_reg     <= level_next;
        end
    end

    assign result.valve_cmd       = valve;
    assign result.totaliser_drive = level_next;
    assign result.dispense_done   = done_next;
    assign result.pulses_left     = remaining_next;
    assign result.pulses_seen     = count;

endmodule

`default_nettype wire

### dv/testbench.sv
// Self-checking testbench of the preset dispense valve controller.
// Drives control ticks on the input stream and checks each result stream transfer
// against a cycle-free model of the tick; depends on pdvc_pkg and the design.
module testbench;

    localparam int CLK_PERIOD      = 12;
    localparam int COUNT_BITS      = 32;
    localparam int PIPE_LATENCY    = 2;
    localparam int RANDOM_TICKS    = 450;
    localparam int PHASE_TICKS     = 70;
    localparam int HOLD_OFF_CYCLES = 150;
    localparam int LIMIT_CYCLES    = 200000;
    localparam logic [31:0] COUNT_MASK = 32'hFFFF_FFFF >> (32 - COUNT_BITS);

    logic                                aclk        = 1'b0;
    logic                                aresetn     = 1'b0;
    logic                                cfg_wr_en   = 1'b0;
    logic [pdvc_pkg::CFG_IDX_BITS-1:0]   cfg_index   = pdvc_pkg::CFG_SLOW_START;
    logic [pdvc_pkg::CFG_DATA_BITS-1:0]  cfg_wr_data = '0;
    logic                                s_tvalid    = 1'b0;
    logic                                s_tready;
    logic [pdvc_pkg::IN_TDATA_BITS-1:0]  s_tdata     = '0;
    logic                                m_tvalid;
    logic                                m_tready    = 1'b0;
    logic [pdvc_pkg::OUT_TDATA_BITS-1:0] m_tdata;

    // Model state and register copies
    logic [32:0] rem_q        = '0;
    logic        done_q       = 1'b0;
    logic [31:0] latch_q      = '0;
    logic [31:0] last_tot_q   = '0;
    logic [15:0] hold_q       = '0;
    logic        level_q      = 1'b0;
    logic [15:0] slow_start_q = 16'd0;
    logic [15:0] slow_end_q   = 16'd0;
    logic [15:0] hold_ticks_q = pdvc_pkg::HOLD_TICKS_RESET;

    pdvc_pkg::result_t results_due[$];
    int      mismatch_count   = 0;
    int      results_checked  = 0;
    int      ticks_sent       = 0;
    int      settings_applied = 0;
    int      hold_offs_done   = 0;
    bit      calm             = 1'b0;
    bit      hold_off_req     = 1'b0;
    logic [31:0] tot_reading  = '0;

    preset_dispense_valve_controller #(
        .COUNT_BITS (COUNT_BITS)
    ) u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    function automatic logic is_positive(input logic [32:0] v);
        return v != '0 && !v[32];
    endfunction

    // Advance the model by one tick and return the result it produces
    function automatic pdvc_pkg::result_t predict_tick(input pdvc_pkg::item_t it);
        pdvc_pkg::result_t r;
        logic        cleared;
        logic [31:0] cnt;
        logic [31:0] tgt;
        cnt = it.pulse_count & COUNT_MASK;
        tgt = it.target_pulses & COUNT_MASK;
        cleared = 1'b0;
        r.valve_cmd = pdvc_pkg::VALVE_STOP;
        if (it.arm)
            rem_q = {1'b0, tgt};
        if (is_positive(rem_q))
            latch_q = cnt;
        if (it.filling) begin
            if (tgt != '0) begin
                if (is_positive(rem_q)) begin
                    done_q = 1'b0;
                    rem_q = {1'b0, tgt} - {1'b0, latch_q};
                    if (!is_positive(rem_q))
                        r.valve_cmd = pdvc_pkg::VALVE_STOP;
                    else if (rem_q >= {17'b0, slow_end_q})
                        r.valve_cmd = (latch_q >= {16'b0, slow_start_q}) ?
                                      pdvc_pkg::VALVE_FAST : pdvc_pkg::VALVE_SLOW;
                    else
                        r.valve_cmd = pdvc_pkg::VALVE_SLOW;
                end else begin
                    done_q = 1'b1;
                    r.valve_cmd = pdvc_pkg::VALVE_STOP;
                end
            end else begin
                r.valve_cmd = pdvc_pkg::VALVE_FAST;
            end
            // Restart the hold on a totaliser change, release once it has run out
            if (it.totaliser_value != last_tot_q) begin
                hold_q = '0;
                level_q = 1'b1;
                cleared = 1'b1;
            end else if (hold_q > hold_ticks_q) begin
                level_q = 1'b0;
            end
            last_tot_q = it.totaliser_value;
        end else begin
            done_q = 1'b0;
            if (hold_q > hold_ticks_q)
                level_q = 1'b0;
            r.valve_cmd = it.calibrating ? pdvc_pkg::VALVE_FAST : pdvc_pkg::VALVE_STOP;
        end
        if (!cleared && hold_q != pdvc_pkg::HOLD_TIMER_MAX)
            hold_q = hold_q + 16'd1;
        r.totaliser_drive = level_q;
        r.dispense_done   = done_q;
        r.pulses_left     = rem_q;
        r.pulses_seen     = cnt;
        return r;
    endfunction

    function automatic pdvc_pkg::item_t make_tick(input logic f, input logic c, input logic a,
                                                  input logic [31:0] cnt,
                                                  input logic [31:0] tgt,
                                                  input logic [31:0] tot);
        pdvc_pkg::item_t it;
        it.filling         = f;
        it.calibrating     = c;
        it.arm             = a;
        it.pulse_count     = cnt;
        it.target_pulses   = tgt;
        it.totaliser_value = tot;
        return it;
    endfunction

    task automatic flag_mismatch(input string what, input logic [32:0] got,
                                 input logic [32:0] want);
        mismatch_count++;
        $display("MISMATCH %s: got 0x%0h, expected 0x%0h", what, got, want);
    endtask

    // Offer one tick, now and then after a random idle gap unless calm, and record its result at the transfer
    task automatic send_tick(input pdvc_pkg::item_t it);
        if (!calm && $urandom_range(99) < 12) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(pdvc_pkg::IN_TDATA_BITS - $bits(pdvc_pkg::item_t)){1'b0}}, it};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        results_due.push_back(predict_tick(it));
        ticks_sent++;
    endtask

    // Drop valid and wait until every predicted result has arrived
    task automatic drain();
        s_tvalid <= 1'b0;
        while (results_due.size() != 0) @(posedge aclk);
        repeat (PIPE_LATENCY + 4) @(posedge aclk);
    endtask

    // Write all three registers on consecutive edges; the block is idle here
    task automatic apply_settings(input logic [15:0] ss, input logic [15:0] se,
                                  input logic [15:0] ht);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= pdvc_pkg::CFG_SLOW_START;
        cfg_wr_data <= ss;
        @(posedge aclk);
        slow_start_q = ss;
        cfg_index   <= pdvc_pkg::CFG_SLOW_END;
        cfg_wr_data <= se;
        @(posedge aclk);
        slow_end_q = se;
        cfg_index   <= pdvc_pkg::CFG_HOLD_TICKS;
        cfg_wr_data <= ht;
        @(posedge aclk);
        hold_ticks_q = ht;
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        settings_applied++;
    endtask

    // One dispense transaction: arm, fill with rising counts, then a few idle ticks
    task automatic run_fill_cycle();
        logic [31:0] cnt;
        logic [31:0] tgt;
        int          roll;
        int          n;
        int          cap;
        roll = $urandom_range(99);
        if (roll < 5)
            tgt = '0;
        else if (roll < 10)
            tgt = $urandom;
        else
            tgt = $urandom_range(1, 400);
        cnt = ($urandom_range(9) == 0) ? $urandom : $urandom_range(0, 3);
        cap = (tgt == '0 || tgt > 32'd400) ? $urandom_range(5, 30) : 150;
        send_tick(make_tick($urandom_range(3) != 0, 1'($urandom_range(1)), 1'b1,
                            cnt, tgt, tot_reading));
        n = 0;
        while (n < cap && !(done_q && $urandom_range(2) == 0)) begin
            cnt = cnt + $urandom_range(0, 6);
            if ($urandom_range(3) == 0)
                tot_reading = tot_reading + 1;
            roll = $urandom_range(99);
            if (roll < 6)
                send_tick(pdvc_pkg::item_t'({$urandom, $urandom, $urandom, 3'($urandom)}));
            else if (roll < 9)
                send_tick(make_tick(1'b1, 1'($urandom_range(1)), 1'b1, cnt, tgt,
                                    tot_reading));
            else if (roll < 12)
                send_tick(make_tick(1'b0, 1'($urandom_range(1)), 1'b0, cnt, tgt,
                                    tot_reading));
            else
                send_tick(make_tick(1'b1, 1'($urandom_range(1)), 1'b0, cnt, tgt,
                                    tot_reading));
            n++;
        end
        repeat ($urandom_range(1, 3))
            send_tick(make_tick(1'b0, 1'($urandom_range(1)), 1'b0, cnt, tgt, $urandom));
    endtask

    // Reset defaults, extreme counts, reloads, completion and the hold edge cases
    task automatic test_directed();
        send_tick(make_tick(1'b0, 1'b0, 1'b0, 32'h0, 32'h0, 32'h0));
        send_tick(make_tick(1'b0, 1'b1, 1'b0, '1, '1, '1));
        send_tick(make_tick(1'b1, 1'b0, 1'b0, 32'h0, 32'h0, 32'd5));
        send_tick(make_tick(1'b1, 1'b0, 1'b1, 32'h0, '1, 32'd5));
        send_tick(make_tick(1'b1, 1'b0, 1'b0, 32'd100, '1, 32'd6));
        // reload while already running
        send_tick(make_tick(1'b1, 1'b0, 1'b1, 32'd10, 32'd50, 32'd6));
        send_tick(make_tick(1'b1, 1'b0, 1'b0, 32'd50, 32'd50, 32'd6));
        send_tick(make_tick(1'b1, 1'b0, 1'b0, 32'd51, 32'd50, 32'd6));
        // overshoot to a negative remaining count, completion on the next tick
        send_tick(make_tick(1'b1, 1'b0, 1'b1, '1, 32'd1, 32'd7));
        send_tick(make_tick(1'b1, 1'b0, 1'b0, 32'h0, 32'd1, 32'd7));
        // no preset while filling keeps completion and remaining
        send_tick(make_tick(1'b1, 1'b0, 1'b0, 32'h0, 32'h0, 32'd7));
        send_tick(make_tick(1'b0, 1'b0, 1'b0, 32'h0, 32'h0, 32'd7));
        drain();
        // top thresholds and a zero hold
        apply_settings(16'hFFFF, 16'hFFFF, 16'd0);
        send_tick(make_tick(1'b1, 1'b0, 1'b1, 32'd0, 32'd200000, 32'd8));
        send_tick(make_tick(1'b1, 1'b0, 1'b0, 32'd70000, 32'd200000, 32'd8));
        send_tick(make_tick(1'b1, 1'b0, 1'b0, 32'd150000, 32'd200000, 32'd8));
        send_tick(make_tick(1'b0, 1'b1, 1'b0, 32'd0, 32'd0, 32'd9));
        drain();
        // longest hold keeps the totaliser output active
        apply_settings(16'd0, 16'd0, 16'hFFFF);
        send_tick(make_tick(1'b1, 1'b0, 1'b0, 32'd0, 32'd0, 32'd10));
        repeat (3) send_tick(make_tick(1'b1, 1'b0, 1'b0, 32'd0, 32'd0, 32'd10));
        send_tick(make_tick(1'b0, 1'b0, 1'b0, 32'd0, 32'd0, 32'd10));
        drain();
        tot_reading = 32'd10;
    endtask

    // Transactions over a series of register settings, the extremes among them
    task automatic test_random_fills();
        int goal;
        int p;
        int phase_start;
        goal = ticks_sent + RANDOM_TICKS;
        p = 0;
        while (ticks_sent < goal) begin
            calm = (p == 1);
            case (p % 6)
                0: apply_settings(16'd0, 16'd0, 16'd0);
                1: apply_settings(16'($urandom_range(0, 200)), 16'($urandom_range(0, 200)),
                                  16'($urandom_range(0, 15)));
                2: apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF);
                3: apply_settings(16'd0, 16'hFFFF, pdvc_pkg::HOLD_TICKS_RESET);
                default: apply_settings(16'($urandom_range(0, 400)),
                                        16'($urandom_range(0, 400)),
                                        16'($urandom_range(0, 40)));
            endcase
            phase_start = ticks_sent;
            while (ticks_sent - phase_start < PHASE_TICKS) run_fill_cycle();
            drain();
            p++;
        end
        calm = 1'b0;
    endtask

    // Hold the result side off while ticks keep coming, so the input stalls
    task automatic test_backpressure();
        int start;
        apply_settings(16'($urandom_range(0, 50)), 16'($urandom_range(0, 50)),
                       16'($urandom_range(0, 10)));
        calm = 1'b1;
        hold_off_req = 1'b1;
        start = ticks_sent;
        while (ticks_sent - start < 40) run_fill_cycle();
        calm = 1'b0;
        drain();
    endtask

    // Result side ready: random stalls, or a counted hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_off_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
                hold_off_req = 1'b0;
                hold_offs_done++;
            end else begin
                m_tready <= calm || ($urandom_range(99) >= 12);
            end
        end
    end

    // Compare each result transfer with the oldest prediction
    always @(posedge aclk) begin
        pdvc_pkg::result_t got;
        pdvc_pkg::result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = pdvc_pkg::result_t'(m_tdata[$bits(pdvc_pkg::result_t)-1:0]);
            if (results_due.size() == 0) begin
                flag_mismatch("result with nothing pending", got.pulses_left, '0);
            end else begin
                want = results_due.pop_front();
                results_checked++;
                if (got.valve_cmd !== want.valve_cmd)
                    flag_mismatch("valve_cmd", got.valve_cmd, want.valve_cmd);
                if (got.totaliser_drive !== want.totaliser_drive)
                    flag_mismatch("totaliser_drive", got.totaliser_drive,
                                  want.totaliser_drive);
                if (got.dispense_done !== want.dispense_done)
                    flag_mismatch("dispense_done", got.dispense_done, want.dispense_done);
                if (got.pulses_left !== want.pulses_left)
                    flag_mismatch("pulses_left", got.pulses_left, want.pulses_left);
                if (got.pulses_seen !== want.pulses_seen)
                    flag_mismatch("pulses_seen", got.pulses_seen, want.pulses_seen);
            end
        end
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random_fills();
        test_backpressure();
        drain();
        $display("Ran %0d ticks under %0d register settings, %0d results checked,",
                 ticks_sent, settings_applied, results_checked);
        $display("with %0d long result-side hold-offs.", hold_offs_done);
        if (mismatch_count == 0)
            $display("preset_dispense_valve_controller: match");
        else
            $display("preset_dispense_valve_controller: mismatch");
        $finish;
    end

    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("Timed out with %0d results outstanding", results_due.size());
        $display("preset_dispense_valve_controller: mismatch");
        $finish;
    end

endmodule
